// File: sv/spieep_pkg.sv
package spieep_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_START_READ  = 2'd0;
  localparam logic [1:0] OP_START_WRITE = 2'd1;
  localparam logic [1:0] OP_BYTE_DONE   = 2'd2;

  // Serial EEPROM command bytes and status bits.
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_WRITE  = 8'h02;
  localparam logic [7:0] CMD_WREN   = 8'h06;
  localparam logic [7:0] CMD_RDSR   = 8'h05;
  localparam logic [7:0] DUMMY_BYTE = 8'hFF;
  localparam logic [7:0] STATUS_WIP = 8'h01;

  // Sequencer phases.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_RDSR  = 4'd1;
  localparam logic [3:0] PH_STAT  = 4'd2;
  localparam logic [3:0] PH_WREN  = 4'd3;
  localparam logic [3:0] PH_CMD   = 4'd4;
  localparam logic [3:0] PH_AHI   = 4'd5;
  localparam logic [3:0] PH_ALO   = 4'd6;
  localparam logic [3:0] PH_WDATA = 4'd7;
  localparam logic [3:0] PH_RDATA = 4'd8;

  // Working width for address byte extraction; covers every legal address width.
  localparam int ADDR_EXT_WIDTH = 24;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] mem_address;
    logic [15:0] byte_count;
    logic [7:0]  rx_byte;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_active;
    logic       select_gap;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic       rejected;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       is_write;
    logic       first_data_pending;
  } ctrl_t;

endpackage

// File: sv/spieep_if.sv
interface spieep_item_if;
  logic                 valid;
  logic                 ready;
  spieep_pkg::item_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spieep_result_if;
  logic                 valid;
  logic                 ready;
  spieep_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/spieep_step.sv
module spieep_step #(
  parameter int ADDR_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  spieep_pkg::item_t         item,
  input  spieep_pkg::ctrl_t         ctrl,
  input  logic [ADDR_WIDTH-1:0]     held_address,
  input  logic [COUNT_WIDTH-1:0]    bytes_left,
  output spieep_pkg::ctrl_t         ctrl_next,
  output logic [ADDR_WIDTH-1:0]     held_address_next,
  output logic [COUNT_WIDTH-1:0]    bytes_left_next,
  output spieep_pkg::result_t       res
);

  logic [spieep_pkg::ADDR_EXT_WIDTH-1:0] addr_ext;
  logic [COUNT_WIDTH-1:0]                count_dec;

  assign addr_ext  = spieep_pkg::ADDR_EXT_WIDTH'(held_address);
  assign count_dec = bytes_left - COUNT_WIDTH'(1);

  always_comb begin
    ctrl_next         = ctrl;
    held_address_next = held_address;
    bytes_left_next   = bytes_left;
    res               = '0;

    unique case (item.op)
      spieep_pkg::OP_START_READ, spieep_pkg::OP_START_WRITE: begin
        if (ctrl.phase != spieep_pkg::PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          ctrl_next.is_write           = item.op[0];
          ctrl_next.first_data_pending = 1'b0;
          ctrl_next.phase              = spieep_pkg::PH_RDSR;
          held_address_next            = ADDR_WIDTH'(item.mem_address);
          bytes_left_next              = COUNT_WIDTH'(item.byte_count);
          res.tx_valid                 = 1'b1;
          res.tx_byte                  = spieep_pkg::CMD_RDSR;
        end
      end
      spieep_pkg::OP_BYTE_DONE: begin
        unique case (ctrl.phase)
          spieep_pkg::PH_RDSR: begin
            res.tx_valid    = 1'b1;
            res.tx_byte     = spieep_pkg::DUMMY_BYTE;
            ctrl_next.phase = spieep_pkg::PH_STAT;
          end
          spieep_pkg::PH_STAT: begin
            res.tx_valid   = 1'b1;
            res.select_gap = 1'b1;
            priority if ((item.rx_byte & spieep_pkg::STATUS_WIP) != 8'h00) begin
              res.tx_byte     = spieep_pkg::CMD_RDSR;
              ctrl_next.phase = spieep_pkg::PH_RDSR;
            end else if (ctrl.is_write) begin
              res.tx_byte     = spieep_pkg::CMD_WREN;
              ctrl_next.phase = spieep_pkg::PH_WREN;
            end else begin
              res.tx_byte     = spieep_pkg::CMD_READ;
              ctrl_next.phase = spieep_pkg::PH_CMD;
            end
          end
          spieep_pkg::PH_WREN: begin
            res.tx_valid    = 1'b1;
            res.select_gap  = 1'b1;
            res.tx_byte     = spieep_pkg::CMD_WRITE;
            ctrl_next.phase = spieep_pkg::PH_CMD;
          end
          spieep_pkg::PH_CMD: begin
            res.tx_valid    = 1'b1;
            res.tx_byte     = addr_ext[15:8];
            ctrl_next.phase = spieep_pkg::PH_AHI;
          end
          spieep_pkg::PH_AHI: begin
            res.tx_valid                 = 1'b1;
            res.tx_byte                  = addr_ext[7:0];
            ctrl_next.first_data_pending = 1'b1;
            ctrl_next.phase              = spieep_pkg::PH_ALO;
          end
          spieep_pkg::PH_ALO, spieep_pkg::PH_WDATA: begin
            // Reads with a count go to dummy reads; writes stream data; else done.
            priority if (ctrl.phase == spieep_pkg::PH_ALO && !ctrl.is_write &&
                         bytes_left != '0) begin
              res.tx_valid    = 1'b1;
              res.tx_byte     = spieep_pkg::DUMMY_BYTE;
              ctrl_next.phase = spieep_pkg::PH_RDATA;
            end else if ((ctrl.phase == spieep_pkg::PH_WDATA || ctrl.is_write) &&
                         bytes_left != '0) begin
              res.tx_valid                 = 1'b1;
              res.tx_byte                  = item.write_data;
              bytes_left_next              = count_dec;
              ctrl_next.first_data_pending = 1'b0;
              ctrl_next.phase              = spieep_pkg::PH_WDATA;
            end else begin
              ctrl_next.first_data_pending = 1'b0;
              ctrl_next.phase              = spieep_pkg::PH_IDLE;
              res.done_res                 = 1'b1;
            end
          end
          spieep_pkg::PH_RDATA: begin
            res.read_valid               = 1'b1;
            res.read_byte                = item.rx_byte;
            ctrl_next.first_data_pending = 1'b0;
            bytes_left_next              = count_dec;
            if (count_dec != '0) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = spieep_pkg::DUMMY_BYTE;
            end else begin
              ctrl_next.phase = spieep_pkg::PH_IDLE;
              res.done_res    = 1'b1;
            end
          end
          default: begin
            ctrl_next.phase = spieep_pkg::PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase

    res.select_active = (ctrl_next.phase != spieep_pkg::PH_IDLE);
    res.busy_res      = (ctrl_next.phase != spieep_pkg::PH_IDLE);
  end

endmodule

// File: sv/spi_eeprom_transaction_sequencer_top.sv
// SPI serial EEPROM transaction sequencer. Each input beat is either a start
// (read or write, with address and byte count) or a byte-done event carrying the
// byte just clocked in from the device; every accepted beat produces exactly one
// result beat telling the SPI shifter what to send next, whether to pulse chip
// select, and whether a read data byte, completion or rejection occurred. A
// transaction first polls the status register until the write-in-progress bit
// clears, then issues write enable and write, or read, followed by two address
// bytes and the data phase. The block takes one beat per clock: the next-state
// logic is a single short combinational step feeding the state registers and a
// result register, and a new beat is accepted whenever the result register is
// empty or is being drained in the same cycle; the result beat is registered.
module spi_eeprom_transaction_sequencer_top #(
  parameter int ADDR_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  spieep_item_if.sink             item,
  spieep_result_if.source         result
);

  // Sequencer state.
  spieep_pkg::ctrl_t        ctrl;
  spieep_pkg::ctrl_t        ctrl_next;
  logic [ADDR_WIDTH-1:0]    held_address;
  logic [ADDR_WIDTH-1:0]    held_address_next;
  logic [COUNT_WIDTH-1:0]   bytes_left;
  logic [COUNT_WIDTH-1:0]   bytes_left_next;

  // Result register.
  spieep_pkg::result_t      res_next;
  spieep_pkg::result_t      res_data;
  logic                     res_valid;

  logic                     accept;

  // The result register frees up in the same cycle it is drained, so the
  // input stays open as long as the consumer keeps up.
  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  spieep_step #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .item              (item.data),
    .ctrl              (ctrl),
    .held_address      (held_address),
    .bytes_left        (bytes_left),
    .ctrl_next         (ctrl_next),
    .held_address_next (held_address_next),
    .bytes_left_next   (bytes_left_next),
    .res               (res_next)
  );

  // State advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl         <= '0;
      held_address <= '0;
      bytes_left   <= '0;
    end else if (accept) begin
      ctrl         <= ctrl_next;
      held_address <= held_address_next;
      bytes_left   <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload needs no reset; it is qualified by res_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

endmodule

// File: sim/tb_spi_eeprom_transaction_sequencer_top.sv
module tb_spi_eeprom_transaction_sequencer_top;
  import spieep_pkg::*;

  // The package names only the three meaningful opcodes; the fourth value must be
  // ignored by the block, so the bench gives it a name of its own.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Longest run of cycles without any handshake before the run is declared hung.
  // The deliberate receiver hold-off, HOLD_CYCLES, is far shorter, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 360;

  // Scoreboard: it carries its own copy of the sequencer state, turns every
  // accepted input beat into the one result beat the block must produce, and
  // compares the result beats in order as they are accepted.
  class seq_scoreboard;
    logic [3:0]  phase;
    logic        is_write;
    logic [15:0] held_address;
    logic [15:0] bytes_left;
    logic        first_data_pending;
    result_t     awaited_results[$];
    int          mismatches;
    int          results_seen;
    int          read_bytes;
    int          transfers_done;
    int          starts_rejected;

    function new();
      phase = PH_IDLE;
      is_write = 1'b0;
      held_address = '0;
      bytes_left = '0;
      first_data_pending = 1'b0;
    endfunction

    function void put_tx(inout result_t r, input logic [7:0] b, input logic gap);
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.select_gap = gap;
    endfunction

    function result_t sequence_step(item_t it);
      result_t r;
      r = '0;
      case (it.op)
        OP_START_READ, OP_START_WRITE: begin
          if (phase != PH_IDLE) begin
            r.rejected = 1'b1;
          end else begin
            is_write = (it.op == OP_START_WRITE);
            held_address = it.mem_address;
            bytes_left = it.byte_count;
            first_data_pending = 1'b0;
            put_tx(r, CMD_RDSR, 1'b0);
            phase = PH_RDSR;
          end
        end
        OP_BYTE_DONE: begin
          case (phase)
            PH_RDSR: begin
              put_tx(r, DUMMY_BYTE, 1'b0);
              phase = PH_STAT;
            end
            PH_STAT: begin
              if ((it.rx_byte & STATUS_WIP) != 8'h00) begin
                put_tx(r, CMD_RDSR, 1'b1);
                phase = PH_RDSR;
              end else if (is_write) begin
                put_tx(r, CMD_WREN, 1'b1);
                phase = PH_WREN;
              end else begin
                put_tx(r, CMD_READ, 1'b1);
                phase = PH_CMD;
              end
            end
            PH_WREN: begin
              put_tx(r, CMD_WRITE, 1'b1);
              phase = PH_CMD;
            end
            PH_CMD: begin
              put_tx(r, held_address[15:8], 1'b0);
              phase = PH_AHI;
            end
            PH_AHI: begin
              put_tx(r, held_address[7:0], 1'b0);
              first_data_pending = 1'b1;
              phase = PH_ALO;
            end
            PH_ALO, PH_WDATA: begin
              if (phase == PH_ALO && !is_write) begin
                if (bytes_left != 16'd0) begin
                  put_tx(r, DUMMY_BYTE, 1'b0);
                  phase = PH_RDATA;
                end else begin
                  first_data_pending = 1'b0;
                  r.done_res = 1'b1;
                  phase = PH_IDLE;
                end
              end else if (bytes_left != 16'd0) begin
                put_tx(r, it.write_data, 1'b0);
                bytes_left = bytes_left - 16'd1;
                first_data_pending = 1'b0;
                phase = PH_WDATA;
              end else begin
                first_data_pending = 1'b0;
                r.done_res = 1'b1;
                phase = PH_IDLE;
              end
            end
            PH_RDATA: begin
              r.read_valid = 1'b1;
              r.read_byte = it.rx_byte;
              first_data_pending = 1'b0;
              bytes_left = bytes_left - 16'd1;
              if (bytes_left != 16'd0) begin
                put_tx(r, DUMMY_BYTE, 1'b0);
              end else begin
                r.done_res = 1'b1;
                phase = PH_IDLE;
              end
            end
            default: begin
              phase = PH_IDLE;
            end
          endcase
        end
        default: ;
      endcase
      r.select_active = (phase != PH_IDLE);
      r.busy_res = (phase != PH_IDLE);
      return r;
    endfunction

    function void note_item(item_t it);
      awaited_results.push_back(sequence_step(it));
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 60) $display("MISMATCH: %s", msg);
    endtask

    task check_result(result_t got);
      result_t want;
      string   tag;
      results_seen++;
      tag = $sformatf("result %0d", results_seen);
      if (awaited_results.size() == 0) begin
        report($sformatf("%s arrived with no beat awaiting it", tag));
      end else begin
        want = awaited_results.pop_front();
        if (want.read_valid) read_bytes++;
        if (want.done_res) transfers_done++;
        if (want.rejected) starts_rejected++;
        if (got.tx_valid !== want.tx_valid)
          report($sformatf("%s tx_valid %b, want %b", tag, got.tx_valid, want.tx_valid));
        if (got.tx_byte !== want.tx_byte)
          report($sformatf("%s tx_byte %h, want %h", tag, got.tx_byte, want.tx_byte));
        if (got.select_active !== want.select_active)
          report($sformatf("%s select_active %b, want %b", tag, got.select_active,
                           want.select_active));
        if (got.select_gap !== want.select_gap)
          report($sformatf("%s select_gap %b, want %b", tag, got.select_gap, want.select_gap));
        if (got.read_valid !== want.read_valid)
          report($sformatf("%s read_valid %b, want %b", tag, got.read_valid, want.read_valid));
        if (got.read_byte !== want.read_byte)
          report($sformatf("%s read_byte %h, want %h", tag, got.read_byte, want.read_byte));
        if (got.done_res !== want.done_res)
          report($sformatf("%s done_res %b, want %b", tag, got.done_res, want.done_res));
        if (got.rejected !== want.rejected)
          report($sformatf("%s rejected %b, want %b", tag, got.rejected, want.rejected));
        if (got.busy_res !== want.busy_res)
          report($sformatf("%s busy_res %b, want %b", tag, got.busy_res, want.busy_res));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  spieep_item_if   item_ch ();
  spieep_result_if res_ch ();

  spi_eeprom_transaction_sequencer_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  seq_scoreboard sb;

  // Idle percentages for the two sides; the main process changes them per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Remaining cycles of a forced receiver hold-off; counted down by the receiver.
  int hold_left = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  // Receiver side. Ready changes only on the falling edge, so the block sees a
  // stable value at every rising edge. A pending hold-off takes priority over
  // the random stall.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. Both channels are sampled at the rising edge, before the block's
  // registers take their new values. A result beat always belongs to an earlier
  // input beat, so the result is checked before the new input beat is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
      if (item_ch.valid && item_ch.ready) sb.note_item(item_ch.data);
    end
  end

  // Watchdog: any cycle with a handshake on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_item(logic [1:0] op, logic [15:0] addr, logic [15:0] cnt,
                                      logic [7:0] rx, logic [7:0] wd);
    item_t it;
    it.op = op;
    it.mem_address = addr;
    it.byte_count = cnt;
    it.rx_byte = rx;
    it.write_data = wd;
    return it;
  endfunction

  // Offers one input beat, starting at a falling edge, with random idle cycles
  // in front of it. Valid stays high after the beat is taken; the next call
  // either replaces the payload or lowers valid, so the same beat is never
  // offered twice. Returns at the falling edge after the handshake, by which
  // time the scoreboard has already noted the beat.
  task automatic drive_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.data <= it;
    item_ch.valid <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every result owed by the block has come back.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.awaited_results.size() != 0);
  endtask

  // A beat that a busy block must not act on: a start, which is rejected, or the
  // unused opcode. All payload fields are random so every bit gets exercised.
  function automatic item_t busy_noise();
    logic [1:0] op;
    case ($urandom_range(2))
      0: op = OP_START_READ;
      1: op = OP_START_WRITE;
      default: op = OP_UNUSED;
    endcase
    return make_item(op, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Feeds byte-done beats until the transaction in flight ends. The scoreboard's
  // phase tells when the status reply is due; the first wip_polls replies report
  // write in progress so that the status poll repeats.
  task automatic complete_transaction(int wip_polls, int noise_pct);
    item_t it;
    while (sb.phase != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        drive_item(busy_noise());
      end else begin
        it = make_item(OP_BYTE_DONE, 16'($urandom), 16'($urandom), 8'($urandom),
                       8'($urandom));
        if (sb.phase == PH_STAT) begin
          it.rx_byte[0] = (wip_polls > 0);
          if (wip_polls > 0) wip_polls--;
        end
        drive_item(it);
      end
    end
  endtask

  // One well-formed transaction with random content. Counts are kept small so
  // most beats go through the command and address phases; about one transfer in
  // ten is longer. Occasionally a stray beat is sent while the block is idle.
  task automatic random_transaction(int noise_pct);
    logic [15:0] cnt;
    logic [1:0]  op;
    if ($urandom_range(9) == 0) cnt = 16'($urandom_range(40, 9));
    else cnt = 16'($urandom_range(8));
    op = ($urandom_range(1) != 0) ? OP_START_WRITE : OP_START_READ;
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1) != 0)
        drive_item(make_item(OP_BYTE_DONE, 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom)));
      else
        drive_item(make_item(OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom)));
    end
    drive_item(make_item(op, 16'($urandom), cnt, 8'($urandom), 8'($urandom)));
    complete_transaction($urandom_range(2), noise_pct);
  endtask

  initial begin
    int target;
    sb = new();
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed beats, no idling. A byte-done and the unused opcode while idle
    // must both leave the block untouched, here with every field at its maximum.
    drive_item(make_item(OP_BYTE_DONE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    drive_item(make_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    // Read at the top address with a zero count: the status poll repeats once,
    // and the transfer ends right after the low address byte.
    drive_item(make_item(OP_START_READ, 16'hFFFF, 16'h0000, 8'h00, 8'h00));
    complete_transaction(1, 0);
    // Single-byte write at address zero. While it runs, a start with all fields
    // at their maximum must be rejected and the unused opcode ignored. The step
    // that completes the last data byte also releases chip select.
    drive_item(make_item(OP_START_WRITE, 16'h0000, 16'h0001, 8'h00, 8'h00));
    drive_item(make_item(OP_START_READ, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    drive_item(make_item(OP_UNUSED, 16'h0000, 16'h0000, 8'h00, 8'h00));
    complete_transaction(0, 0);

    // Random transactions in four idling phases. Between phases the sender
    // waits for every owed result, so each phase starts from a quiet block.
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      random_transaction(8);
      // In the first phase the receiver stops for a long stretch while the
      // sender keeps offering, so the result register fills and input stalls.
      if (ph == 0) hold_left = HOLD_CYCLES;
      while (items_sent < target) random_transaction(8);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.awaited_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited_results.size()));

    $display("Sent %0d input beats over four idling phases; checked %0d result beats.",
             items_sent, sb.results_seen);
    $display("Seen: %0d finished transfers, %0d read bytes, %0d rejected starts, %0d mismatches.",
             sb.transfers_done, sb.read_bytes, sb.starts_rejected, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/spieep_pkg.sv
sv/spieep_if.sv
sv/spieep_step.sv
sv/spi_eeprom_transaction_sequencer_top.sv
sim/tb_spi_eeprom_transaction_sequencer_top.sv
